/* hw/rtl/imhtq_pkg.sv */
package imhtq_pkg;

   localparam int ID_COUNT      = 64;
   localparam int ID_W          = 6;
   localparam int WAIT_W        = 32;
   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_TIME_BITS = 32;

   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_DEL  = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_TICK_CHK,
      S_TICK_CMP,
      S_RM_CHK,
      S_RM_LD,
      S_DOWN_RD,
      S_DOWN_RD2,
      S_DOWN_CMP2,
      S_DOWN_CMP,
      S_DOWN_END,
      S_UP_RD,
      S_UP_CMP,
      S_PLACE,
      S_FIN,
      S_FIN_W,
      S_EMIT_RD,
      S_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic take;
      logic load_known;
      logic load_new;
      logic st_full;
      logic st_absent;
      logic rm_from_pos;
      logic root_rd;
      logic pop;
      logic rm_last_rd;
      logic rm_drop;
      logic rm_load;
      logic c_rd;
      logic best_ld;
      logic c1_rd;
      logic best_pick;
      logic down_move;
      logic p_rd;
      logic up_move;
      logic place;
      logic wait_calc;
      logic fm_rd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic func_add;
      logic func_del;
      logic func_tick;
      logic pos_valid;
      logic full;
      logic cnt_zero;
      logic i_lt_last;
      logic c_in;
      logic c1_in;
      logic e_less_best;
      logic par_less;
      logic i_zero;
      logic moved;
      logic due;
      logic out_free;
      logic none_fired;
      logic emit_last;
   } stat_type;

endpackage

/* hw/rtl/imhtq_if.sv */
interface imhtq_req_if #(
   parameter int TIME_BITS = imhtq_pkg::DEF_TIME_BITS
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             func;
   logic [5:0]             timer_id;
   logic [TIME_BITS-1:0]   expire_time;
   logic [TIME_BITS-1:0]   now;

   modport source (output valid, func, timer_id, expire_time, now, input ready);
   modport sink   (input valid, func, timer_id, expire_time, now, output ready);
endinterface

interface imhtq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        fired_valid;
   logic [5:0]  fired_id;
   logic [31:0] next_wait;
   logic        queue_empty;
   logic        last;

   modport source (output valid, status, fired_valid, fired_id, next_wait, queue_empty,
                   last, input ready);
   modport sink   (input valid, status, fired_valid, fired_id, next_wait, queue_empty,
                   last, output ready);
endinterface

/* hw/rtl/imhtq_ctrl.sv */
module imhtq_ctrl import imhtq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.func_add) begin
               if (stat.pos_valid)  state_in = S_DOWN_RD;
               else if (stat.full)  state_in = S_FIN;
               else                 state_in = S_UP_RD;
            end else if (stat.func_del) begin
               state_in = stat.pos_valid ? S_RM_CHK : S_FIN;
            end else if (stat.func_tick) begin
               state_in = S_TICK_CHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_TICK_CHK:  state_in = stat.cnt_zero ? S_FIN : S_TICK_CMP;
         S_TICK_CMP:  state_in = stat.due ? S_RM_CHK : S_FIN;
         S_RM_CHK: begin
            if (stat.i_lt_last)      state_in = S_RM_LD;
            else if (stat.func_tick) state_in = S_TICK_CHK;
            else                     state_in = S_FIN;
         end
         S_RM_LD:     state_in = S_DOWN_RD;
         S_DOWN_RD:   state_in = stat.c_in ? S_DOWN_RD2 : S_DOWN_END;
         S_DOWN_RD2:  state_in = stat.c1_in ? S_DOWN_CMP2 : S_DOWN_CMP;
         S_DOWN_CMP2: state_in = S_DOWN_CMP;
         S_DOWN_CMP:  state_in = stat.e_less_best ? S_DOWN_END : S_DOWN_RD;
         S_DOWN_END:  state_in = stat.moved ? S_PLACE : S_UP_RD;
         S_UP_RD:     state_in = stat.i_zero ? S_PLACE : S_UP_CMP;
         S_UP_CMP:    state_in = stat.par_less ? S_PLACE : S_UP_RD;
         S_PLACE:     state_in = stat.func_tick ? S_TICK_CHK : S_FIN;
         S_FIN:       state_in = stat.cnt_zero ? S_EMIT_RD : S_FIN_W;
         S_FIN_W:     state_in = S_EMIT_RD;
         S_EMIT_RD:   state_in = S_EMIT_OUT;
         S_EMIT_OUT: begin
            if (stat.out_free) state_in = stat.emit_last ? S_IDLE : S_EMIT_RD;
         end
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         S_DECODE: begin
            if (stat.func_add) begin
               if (stat.pos_valid)  cmd.load_known = 1'b1;
               else if (stat.full)  cmd.st_full    = 1'b1;
               else                 cmd.load_new   = 1'b1;
            end else if (stat.func_del) begin
               if (stat.pos_valid) cmd.rm_from_pos = 1'b1;
               else                cmd.st_absent   = 1'b1;
            end
         end
         S_TICK_CHK:  cmd.root_rd = !stat.cnt_zero;
         S_TICK_CMP:  cmd.pop     = stat.due;
         S_RM_CHK: begin
            cmd.rm_last_rd = stat.i_lt_last;
            cmd.rm_drop    = !stat.i_lt_last;
         end
         S_RM_LD: begin
            cmd.rm_drop = 1'b1;
            cmd.rm_load = 1'b1;
         end
         S_DOWN_RD:   cmd.c_rd = stat.c_in;
         S_DOWN_RD2: begin
            cmd.best_ld = 1'b1;
            cmd.c1_rd   = stat.c1_in;
         end
         S_DOWN_CMP2: cmd.best_pick = 1'b1;
         S_DOWN_CMP:  cmd.down_move = !stat.e_less_best;
         S_DOWN_END:  ;
         S_UP_RD:     cmd.p_rd    = !stat.i_zero;
         S_UP_CMP:    cmd.up_move = !stat.par_less;
         S_PLACE:     cmd.place   = 1'b1;
         S_FIN: begin
            cmd.root_rd   = !stat.cnt_zero;
            cmd.wait_calc = stat.cnt_zero;
         end
         S_FIN_W:     cmd.wait_calc = 1'b1;
         S_EMIT_RD:   cmd.fm_rd     = !stat.none_fired;
         S_EMIT_OUT:  cmd.emit      = stat.out_free;
         default:     ;
      endcase
   end

endmodule

/* hw/rtl/imhtq_dp.sv */
module imhtq_dp import imhtq_pkg::*; #(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [1:0]           req_func,
   input  logic [ID_W-1:0]      req_timer_id,
   input  logic [TIME_BITS-1:0] req_expire_time,
   input  logic [TIME_BITS-1:0] req_now,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic                 rsp_fired_valid,
   output logic [ID_W-1:0]      rsp_fired_id,
   output logic [WAIT_W-1:0]    rsp_next_wait,
   output logic                 rsp_queue_empty,
   output logic                 rsp_last
);

   localparam int SLOTS  = (CAPACITY < ID_COUNT) ? CAPACITY : ID_COUNT;
   localparam int HIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int XW     = HIDX_W + 2;
   localparam int FC_W   = $clog2(ID_COUNT + 1);

   logic [TIME_BITS-1:0] heap_key_mem [SLOTS];
   logic [ID_W-1:0]      heap_id_mem  [SLOTS];
   logic [HIDX_W-1:0]    pos_mem      [ID_COUNT];
   logic [ID_W-1:0]      fired_mem    [ID_COUNT];

   logic [1:0]           func_ff;
   logic [ID_W-1:0]      id_ff;
   logic [TIME_BITS-1:0] exp_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [1:0]           status_ff;
   logic [HIDX_W-1:0]    i_ff, start_ff, c_ff, pos_rd_ff;
   logic [TIME_BITS-1:0] e_key_ff, best_key_ff, hrd_key_ff;
   logic [ID_W-1:0]      e_id_ff, best_id_ff, hrd_id_ff, rm_id_ff, frd_ff;
   logic [XW-1:0]        count_ff;
   logic [ID_COUNT-1:0]  pvalid_ff;
   logic [FC_W-1:0]      nfired_ff, k_ff;
   logic [WAIT_W-1:0]    wait_ff;
   logic                 qe_ff;
   logic                 rsp_valid_ff;

   logic [1:0]           rsp_status_ff;
   logic                 rsp_fired_valid_ff;
   logic [ID_W-1:0]      rsp_fired_id_ff;
   logic [WAIT_W-1:0]    rsp_next_wait_ff;
   logic                 rsp_queue_empty_ff;
   logic                 rsp_last_ff;

   logic [XW-1:0]        c_calc_in;
   logic [XW-1:0]        c1_in;
   logic [HIDX_W-1:0]    parent_in;
   logic [HIDX_W-1:0]    last_in;
   logic                 hr_en_in;
   logic [HIDX_W-1:0]    hr_addr_in;
   logic                 hw_en_in;
   logic [TIME_BITS-1:0] hw_key_in;
   logic [ID_W-1:0]      hw_id_in;
   logic [ID_W-1:0]      pw_addr_in;
   logic [TIME_BITS-1:0] diff_in;
   logic [63:0]          diff_ext_in;
   logic [WAIT_W-1:0]    wait_in;

   assign c_calc_in = {1'b0, i_ff, 1'b1};
   assign c1_in     = XW'(c_ff) + XW'(1);
   assign parent_in = HIDX_W'((i_ff - HIDX_W'(1)) >> 1);
   assign last_in   = HIDX_W'(count_ff - XW'(1));

   always_comb begin
      hr_en_in   = cmd.root_rd | cmd.rm_last_rd | cmd.c_rd | cmd.c1_rd | cmd.p_rd;
      hr_addr_in = '0;
      if (cmd.rm_last_rd) hr_addr_in = last_in;
      if (cmd.c_rd)       hr_addr_in = HIDX_W'(c_calc_in);
      if (cmd.c1_rd)      hr_addr_in = HIDX_W'(c1_in);
      if (cmd.p_rd)       hr_addr_in = parent_in;
      hw_en_in   = cmd.down_move | cmd.up_move | cmd.place;
      hw_key_in  = e_key_ff;
      hw_id_in   = e_id_ff;
      if (cmd.down_move) begin
         hw_key_in = best_key_ff;
         hw_id_in  = best_id_ff;
      end
      if (cmd.up_move) begin
         hw_key_in = hrd_key_ff;
         hw_id_in  = hrd_id_ff;
      end
      pw_addr_in = hw_id_in;
   end

   // heap, position and fired-id stores
   always_ff @(posedge clock) begin
      if (hw_en_in) begin
         heap_key_mem[i_ff] <= hw_key_in;
         heap_id_mem[i_ff]  <= hw_id_in;
         pos_mem[pw_addr_in] <= i_ff;
      end
      if (hr_en_in) begin
         hrd_key_ff <= heap_key_mem[hr_addr_in];
         hrd_id_ff  <= heap_id_mem[hr_addr_in];
      end
      if (cmd.take) begin
         pos_rd_ff <= pos_mem[req_timer_id];
      end
      if (cmd.pop) begin
         fired_mem[nfired_ff[ID_W-1:0]] <= hrd_id_ff;
      end
      if (cmd.fm_rd) begin
         frd_ff <= fired_mem[k_ff[ID_W-1:0]];
      end
   end

   always_comb begin
      diff_in     = (hrd_key_ff > now_ff) ? hrd_key_ff - now_ff : '0;
      diff_ext_in = 64'(diff_in);
      wait_in     = (|diff_ext_in[63:WAIT_W]) ? '1 : diff_ext_in[WAIT_W-1:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pvalid_ff    <= '0;
         nfired_ff    <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take) begin
            nfired_ff <= '0;
            k_ff      <= '0;
         end
         if (cmd.load_new) begin
            count_ff         <= count_ff + XW'(1);
            pvalid_ff[id_ff] <= 1'b1;
         end
         if (cmd.pop) nfired_ff <= nfired_ff + FC_W'(1);
         if (cmd.rm_drop) begin
            count_ff            <= count_ff - XW'(1);
            pvalid_ff[rm_id_ff] <= 1'b0;
         end
         if (cmd.emit) begin
            k_ff         <= k_ff + FC_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         func_ff   <= req_func;
         id_ff     <= req_timer_id;
         exp_ff    <= req_expire_time;
         now_ff    <= req_now;
         status_ff <= ST_OK;
      end
      if (cmd.st_full)   status_ff <= ST_FULL;
      if (cmd.st_absent) status_ff <= ST_ABSENT;
      if (cmd.load_known) begin
         i_ff     <= pos_rd_ff;
         start_ff <= pos_rd_ff;
         e_key_ff <= exp_ff;
         e_id_ff  <= id_ff;
      end
      if (cmd.load_new) begin
         i_ff     <= HIDX_W'(count_ff);
         e_key_ff <= exp_ff;
         e_id_ff  <= id_ff;
      end
      if (cmd.rm_from_pos) begin
         i_ff     <= pos_rd_ff;
         rm_id_ff <= id_ff;
      end
      if (cmd.pop) begin
         i_ff     <= '0;
         rm_id_ff <= hrd_id_ff;
      end
      if (cmd.rm_load) begin
         e_key_ff <= hrd_key_ff;
         e_id_ff  <= hrd_id_ff;
         start_ff <= i_ff;
      end
      if (cmd.c_rd) c_ff <= HIDX_W'(c_calc_in);
      if (cmd.best_ld) begin
         best_key_ff <= hrd_key_ff;
         best_id_ff  <= hrd_id_ff;
      end
      if (cmd.best_pick && hrd_key_ff < best_key_ff) begin
         best_key_ff <= hrd_key_ff;
         best_id_ff  <= hrd_id_ff;
         c_ff        <= HIDX_W'(c1_in);
      end
      if (cmd.down_move) i_ff <= c_ff;
      if (cmd.up_move)   i_ff <= parent_in;
      if (cmd.wait_calc) begin
         wait_ff <= (count_ff == '0) ? '1 : wait_in;
         qe_ff   <= (count_ff == '0);
      end
      if (cmd.emit) begin
         rsp_status_ff      <= status_ff;
         rsp_fired_valid_ff <= (nfired_ff != '0);
         rsp_fired_id_ff    <= (nfired_ff != '0) ? frd_ff : '0;
         rsp_next_wait_ff   <= wait_ff;
         rsp_queue_empty_ff <= qe_ff;
         rsp_last_ff        <= stat.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fired_valid = rsp_fired_valid_ff;
   assign rsp_fired_id    = rsp_fired_id_ff;
   assign rsp_next_wait   = rsp_next_wait_ff;
   assign rsp_queue_empty = rsp_queue_empty_ff;
   assign rsp_last        = rsp_last_ff;

   always_comb begin
      stat.func_add    = (func_ff == FUNC_ADD);
      stat.func_del    = (func_ff == FUNC_DEL);
      stat.func_tick   = (func_ff == FUNC_TICK);
      stat.pos_valid   = pvalid_ff[id_ff];
      stat.full        = (count_ff >= XW'(SLOTS));
      stat.cnt_zero    = (count_ff == '0);
      stat.i_lt_last   = (XW'(i_ff) + XW'(1) < count_ff);
      stat.c_in        = (c_calc_in < count_ff);
      stat.c1_in       = (c1_in < count_ff);
      stat.e_less_best = (e_key_ff < best_key_ff);
      stat.par_less    = (hrd_key_ff < e_key_ff);
      stat.i_zero      = (i_ff == '0);
      stat.moved       = (i_ff != start_ff);
      stat.due         = !(hrd_key_ff > now_ff);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
      stat.none_fired  = (nfired_ff == '0);
      stat.emit_last   = (nfired_ff == '0) || (k_ff + FC_W'(1) == nfired_ff);
   end

endmodule

/* hw/rtl/indexed_min_heap_timer_queue.sv */
// indexed min-heap timer queue
// req_chan carries one request: add or re-key a timer, delete a timer, or
// tick at the current time. rsp_chan returns the results of each request in
// order; add, delete and unused codes give one result, a tick gives one
// result per expired timer (or one empty result when nothing is due), and
// the final result of a request has last set. every result carries the wait
// until the earliest remaining expiry and the empty flag after the request.
// one request is worked at a time: req_chan.ready is high only while idle,
// which may overlap a result still held in the output register.
// the heap is held in a single-port memory with registered reads: a downward
// sift reads both children per level, an upward one the parent per level; a
// tick pops each due timer and re-sifts the heap, then delivers the results
// in turn. heap depth and the one heap read per cycle set the rate.
// a stalled rsp_chan holds the current result and pauses delivery; the
// queue state is kept meanwhile.
// reset empties the queue at once (per-id valid flags); no clearing pass.
module indexed_min_heap_timer_queue import imhtq_pkg::*; #(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic       clock,
   input  logic       reset,
   imhtq_req_if.sink  req_chan,
   imhtq_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   imhtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   imhtq_dp #(
      .CAPACITY  (CAPACITY),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_chan.func),
      .req_timer_id    (req_chan.timer_id),
      .req_expire_time (req_chan.expire_time),
      .req_now         (req_chan.now),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_fired_valid (rsp_chan.fired_valid),
      .rsp_fired_id    (rsp_chan.fired_id),
      .rsp_next_wait   (rsp_chan.next_wait),
      .rsp_queue_empty (rsp_chan.queue_empty),
      .rsp_last        (rsp_chan.last)
   );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import imhtq_pkg::*;

   localparam int HEAP_SLOTS = 64;
   localparam int CYCLE_LIMIT = 900000;

   typedef struct {
      logic [1:0]  status;
      logic        fired_valid;
      logic [5:0]  fired_id;
      logic [31:0] next_wait;
      logic        queue_empty;
      logic        last;
   } timer_result_type;

   typedef struct {
      logic [1:0]  func;
      logic [5:0]  timer_id;
      logic [31:0] expire_time;
      logic [31:0] now;
      logic        typed;
      logic [1:0]  status;
      logic [31:0] next_wait;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imhtq_req_if req_chan ();
   imhtq_rsp_if rsp_chan ();

   indexed_min_heap_timer_queue i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [31:0] heap_time [HEAP_SLOTS];
   logic [5:0]  heap_id   [HEAP_SLOTS];
   logic        id_present [64];
   int          id_slot    [64];
   int          timer_count;

   timer_result_type pending_results [$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  calm_phase = 0;
   bit  long_hold = 0;

   function automatic void swap_slots(input int a, input int b);
      logic [31:0] t;
      logic [5:0]  d;
      t = heap_time[a]; heap_time[a] = heap_time[b]; heap_time[b] = t;
      d = heap_id[a]; heap_id[a] = heap_id[b]; heap_id[b] = d;
      id_slot[heap_id[a]] = a;
      id_slot[heap_id[b]] = b;
   endfunction

   function automatic void sift_up(input int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (heap_time[p] < heap_time[i]) break;
         swap_slots(p, i);
         i = p;
      end
   endfunction

   function automatic bit sift_down(input int start, input int n);
      int i;
      int c;
      i = start;
      c = 2 * i + 1;
      while (c < n) begin
         if (c + 1 < n && heap_time[c + 1] < heap_time[c]) c = c + 1;
         if (heap_time[i] < heap_time[c]) break;
         swap_slots(i, c);
         i = c;
         c = 2 * i + 1;
      end
      return i > start;
   endfunction

   function automatic void remove_slot(input int i);
      int n;
      logic [5:0] d;
      n = timer_count - 1;
      d = heap_id[i];
      if (i < n) begin
         swap_slots(i, n);
         if (!sift_down(i, n)) sift_up(i);
      end
      timer_count = n;
      id_present[d] = 1'b0;
   endfunction

   // works out the results of one request and queues them
   function automatic void predict_timer_request(input logic [1:0] func,
                                                 input logic [5:0] tid,
                                                 input logic [31:0] exp_t,
                                                 input logic [31:0] now_t);
      logic [5:0]       fired [64];
      int               nfired;
      logic [1:0]       st;
      logic [31:0]      wait_t;
      timer_result_type r;
      int               i;
      st = ST_OK;
      nfired = 0;
      if (func == FUNC_ADD) begin
         if (id_present[tid]) begin
            i = id_slot[tid];
            heap_time[i] = exp_t;
            if (!sift_down(i, timer_count)) sift_up(i);
         end else if (timer_count >= HEAP_SLOTS) begin
            st = ST_FULL;
         end else begin
            i = timer_count;
            heap_time[i] = exp_t;
            heap_id[i] = tid;
            id_present[tid] = 1'b1;
            id_slot[tid] = i;
            timer_count = i + 1;
            sift_up(i);
         end
      end else if (func == FUNC_DEL) begin
         if (id_present[tid]) remove_slot(id_slot[tid]);
         else st = ST_ABSENT;
      end else if (func == FUNC_TICK) begin
         while (timer_count > 0 && nfired < 64) begin
            if (heap_time[0] > now_t) break;
            fired[nfired] = heap_id[0];
            nfired++;
            remove_slot(0);
         end
      end
      if (timer_count == 0) wait_t = 32'hFFFF_FFFF;
      else wait_t = (heap_time[0] > now_t) ? heap_time[0] - now_t : 32'd0;
      r.status = st;
      r.next_wait = wait_t;
      r.queue_empty = (timer_count == 0);
      if (nfired == 0) begin
         r.fired_valid = 1'b0;
         r.fired_id = '0;
         r.last = 1'b1;
         pending_results.insert(pending_results.size(), r);
      end else begin
         for (int k = 0; k < nfired; k++) begin
            r.fired_valid = 1'b1;
            r.fired_id = fired[k];
            r.last = (k == nfired - 1);
            pending_results.insert(pending_results.size(), r);
         end
      end
   endfunction

   // sender
   task automatic send_request(input logic [1:0] func, input logic [5:0] tid,
                               input logic [31:0] exp_t, input logic [31:0] now_t);
      int gap;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= func;
      req_chan.timer_id <= tid;
      req_chan.expire_time <= exp_t;
      req_chan.now <= now_t;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_timer_request(func, tid, exp_t, now_t);
   endtask

   task automatic drop_valid();
      req_chan.valid <= 1'b0;
   endtask

   // receiver
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // checker
   always @(posedge clock) begin
      timer_result_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual id %0d", $time,
                     rsp_chan.fired_id);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_chan.status !== e.status || rsp_chan.fired_valid !== e.fired_valid ||
                rsp_chan.fired_id !== e.fired_id || rsp_chan.next_wait !== e.next_wait ||
                rsp_chan.queue_empty !== e.queue_empty || rsp_chan.last !== e.last) begin
               $display("%0t: mismatch expected st %0d fv %0d id %0d wait %0h emp %0d last %0d",
                        $time, e.status, e.fired_valid, e.fired_id, e.next_wait,
                        e.queue_empty, e.last);
               $display("%0t:          actual st %0d fv %0d id %0d wait %0h emp %0d last %0d",
                        $time, rsp_chan.status, rsp_chan.fired_valid, rsp_chan.fired_id,
                        rsp_chan.next_wait, rsp_chan.queue_empty, rsp_chan.last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   directed_row_type directed_rows [] = '{
      '{FUNC_TICK, 6'd0,  32'd0,          32'd0,          1, ST_OK,     32'hFFFF_FFFF},
      '{FUNC_DEL,  6'd5,  32'd0,          32'd0,          1, ST_ABSENT, 32'hFFFF_FFFF},
      '{FUNC_ADD,  6'd63, 32'hFFFF_FFFF,  32'd0,          1, ST_OK,     32'hFFFF_FFFF},
      '{FUNC_ADD,  6'd0,  32'd0,          32'd0,          0, ST_OK,     32'd0},
      '{FUNC_ADD,  6'd10, 32'd100,        32'd50,         0, ST_OK,     32'd0},
      '{FUNC_ADD,  6'd11, 32'd100,        32'd50,         0, ST_OK,     32'd0},
      '{FUNC_ADD,  6'd12, 32'd100,        32'd50,         0, ST_OK,     32'd0},
      '{FUNC_ADD,  6'd0,  32'd200,        32'd50,         0, ST_OK,     32'd0},
      '{FUNC_ADD,  6'd10, 32'd5,          32'd50,         0, ST_OK,     32'd0},
      '{2'd3,      6'd7,  32'd1,          32'd1,          0, ST_OK,     32'd0},
      '{FUNC_TICK, 6'd0,  32'd0,          32'd4,          0, ST_OK,     32'd0},
      '{FUNC_TICK, 6'd0,  32'd0,          32'd100,        0, ST_OK,     32'd0},
      '{FUNC_DEL,  6'd0,  32'd0,          32'd100,        0, ST_OK,     32'd0},
      '{FUNC_DEL,  6'd0,  32'd0,          32'd100,        1, ST_ABSENT, 32'hFFFF_FF9B},
      '{FUNC_TICK, 6'd0,  32'd0,          32'hFFFF_FFFF,  0, ST_OK,     32'd0},
      '{FUNC_TICK, 6'd0,  32'd0,          32'hFFFF_FFFF,  1, ST_OK,     32'hFFFF_FFFF}
   };

   initial begin
      logic [1:0]  f;
      logic [5:0]  tid;
      logic [31:0] exp_t;
      logic [31:0] now_t;
      logic [31:0] clock_now;
      timer_result_type r;
      int wait_cycles;
      foreach (id_present[k]) begin
         id_present[k] = 1'b0;
         id_slot[k] = 0;
      end
      timer_count = 0;
      req_chan.valid <= 1'b0;
      req_chan.func <= FUNC_ADD;
      req_chan.timer_id <= '0;
      req_chan.expire_time <= '0;
      req_chan.now <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         send_request(directed_rows[k].func, directed_rows[k].timer_id,
                      directed_rows[k].expire_time, directed_rows[k].now);
         if (directed_rows[k].typed) begin
            r = pending_results[pending_results.size() - 1];
            if (r.status !== directed_rows[k].status ||
                r.next_wait !== directed_rows[k].next_wait) begin
               $display("%0t: table row %0d expected st %0d wait %0h actual st %0d wait %0h",
                        $time, k, directed_rows[k].status, directed_rows[k].next_wait,
                        r.status, r.next_wait);
               fail_count++;
            end
         end
      end

      // fill to capacity, then re-key a present timer, while the receiver holds off
      long_hold = 1;
      for (int k = 0; k < 64; k++)
         send_request(FUNC_ADD, k[5:0], $urandom(), 32'd0);
      send_request(FUNC_ADD, 6'd1, 32'd7, 32'd0);
      drop_valid();
      while (pending_results.size() > 0) @(posedge clock);
      for (int k = 0; k < 64; k++) id_present[k] = id_present[k];
      // overflow needs an absent id, which a full queue of 64 ids never has: delete one, add it back, tick all out
      send_request(FUNC_DEL, 6'd3, 32'd0, 32'd0);
      send_request(FUNC_ADD, 6'd3, 32'd9, 32'd0);
      send_request(FUNC_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);

      clock_now = 32'd1000;
      for (int k = 0; k < 200; k++) begin
         if (k > 160) calm_phase = 1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               f = FUNC_ADD;
               exp_t = ($urandom_range(0, 9) == 0) ? $urandom()
                       : clock_now + $urandom_range(0, 60) - 10;
            end
            4, 5:    begin f = FUNC_DEL; exp_t = $urandom(); end
            6, 7, 8: begin f = FUNC_TICK; exp_t = $urandom(); end
            default: begin f = 2'd3; exp_t = $urandom(); end
         endcase
         tid = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 15));
         if (f == FUNC_TICK) clock_now = clock_now + $urandom_range(0, 12);
         now_t = ($urandom_range(0, 19) == 0) ? $urandom() : clock_now;
         send_request(f, tid, exp_t, now_t);
      end
      drop_valid();
      while (pending_results.size() > 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

/* indexed_min_heap_timer_queue.f */
hw/rtl/imhtq_pkg.sv
hw/rtl/imhtq_if.sv
hw/rtl/imhtq_ctrl.sv
hw/rtl/imhtq_dp.sv
hw/rtl/indexed_min_heap_timer_queue.sv
dv/tb_top.sv
